>>> hdl/cocda_pkg.sv
// Package for the CORDIC octant direction angle block.
// Types and widths shared by all pipeline parts, and the arctangent step table for the CORDIC.
// No dependencies.
package cocda_pkg;

    localparam int ITERATIONS   = 12;
    localparam int IN_W         = 16;
    localparam int MAG_W        = IN_W + 1;
    localparam int CW           = 20;
    localparam int AW           = 13;
    localparam int ANG_W        = 12;
    localparam int DIR_W        = 13;

    localparam logic [MAG_W-1:0] SMALL_LIMIT   = MAG_W'(2048);
    localparam logic [ANG_W-1:0] QUARTER_TURN  = ANG_W'(2048);
    localparam logic [DIR_W:0]   DIR_QUARTER   = (DIR_W + 1)'(2048);
    localparam logic [DIR_W:0]   DIR_3_QUARTER = (DIR_W + 1)'(6144);

    typedef struct packed {
        logic signed [IN_W-1:0] vec_x;
        logic signed [IN_W-1:0] vec_y;
    } t_in_req;

    typedef struct packed {
        logic [DIR_W-1:0] direction_angle;
        logic             small_vector;
    } t_out_req;

    typedef struct packed {
        logic is_small;
        logic x_neg;
        logic y_neg;
        logic x_zero;
    } t_meta;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [AW-1:0] acc;
        t_meta                meta;
    } t_work;

    // 1024 = 45 degrees
    function automatic logic signed [AW-1:0] atan_step(input logic [3:0] idx);
        logic signed [AW-1:0] v;
        case (idx)
            4'd0:    v = AW'(1024);
            4'd1:    v = AW'(605);
            4'd2:    v = AW'(319);
            4'd3:    v = AW'(162);
            4'd4:    v = AW'(81);
            4'd5:    v = AW'(41);
            4'd6:    v = AW'(20);
            4'd7:    v = AW'(10);
            4'd8:    v = AW'(5);
            4'd9:    v = AW'(3);
            4'd10:   v = AW'(1);
            4'd11:   v = AW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> hdl/cocda_prep.sv
// Input stage: magnitudes, small-vector test and sign flags, registered.
// Depends on cocda_pkg.
module cocda_prep
    import cocda_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_in_req i_req,
    output logic    o_valid,
    input  logic    i_ready,
    output t_work   o_work
);

    logic             r_valid;
    t_work            r_work;
    t_work            n_work;
    logic [MAG_W-1:0] w_ext_x;
    logic [MAG_W-1:0] w_ext_y;
    logic [MAG_W-1:0] w_mag_x;
    logic [MAG_W-1:0] w_mag_y;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_work  = r_work;

    assign w_ext_x = {i_req.vec_x[IN_W-1], i_req.vec_x};
    assign w_ext_y = {i_req.vec_y[IN_W-1], i_req.vec_y};
    // -32768 gives 32768 as unsigned magnitude
    assign w_mag_x = i_req.vec_x[IN_W-1] ? (~w_ext_x + MAG_W'(1)) : w_ext_x;
    assign w_mag_y = i_req.vec_y[IN_W-1] ? (~w_ext_y + MAG_W'(1)) : w_ext_y;

    always_comb begin
        n_work                = '0;
        n_work.x              = CW'(w_mag_x);
        n_work.y              = CW'(w_mag_y);
        n_work.acc            = '0;
        n_work.meta.is_small  = (w_mag_x < SMALL_LIMIT) && (w_mag_y < SMALL_LIMIT);
        n_work.meta.x_neg     = i_req.vec_x[IN_W-1];
        n_work.meta.y_neg     = i_req.vec_y[IN_W-1];
        n_work.meta.x_zero    = (w_mag_x == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_work <= n_work;
        end
    end

endmodule

>>> hdl/cocda_cordic.sv
// Vectoring CORDIC: one registered stage per iteration, own valid per stage.
// Depends on cocda_pkg.
module cocda_cordic
    import cocda_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_work i_work,
    output logic  o_valid,
    input  logic  i_ready,
    output t_work o_work
);

    logic  r_valid       [ITERATIONS];
    t_work r_work        [ITERATIONS];
    t_work w_src         [ITERATIONS];
    logic  w_src_valid   [ITERATIONS];
    logic  w_stage_ready [ITERATIONS];

    assign o_ready = w_stage_ready[0];
    assign o_valid = r_valid[ITERATIONS-1];
    assign o_work  = r_work[ITERATIONS-1];

    for (genvar k = 0; k < ITERATIONS; k++) begin : g_stage
        logic                 w_down_ready;
        logic signed [CW-1:0] w_xs;
        logic signed [CW-1:0] w_ys;
        t_work                n_work;

        if (k == 0) begin : g_first
            assign w_src[k]       = i_work;
            assign w_src_valid[k] = i_valid;
        end else begin : g_next
            assign w_src[k]       = r_work[k-1];
            assign w_src_valid[k] = r_valid[k-1];
        end

        if (k == ITERATIONS - 1) begin : g_last
            assign w_down_ready = i_ready;
        end else begin : g_mid
            assign w_down_ready = w_stage_ready[k+1];
        end

        assign w_stage_ready[k] = !r_valid[k] || w_down_ready;

        assign w_xs = w_src[k].x >>> k;
        assign w_ys = w_src[k].y >>> k;

        // y == 0 takes the negative branch
        always_comb begin
            n_work = w_src[k];
            if (w_src[k].y > 0) begin
                n_work.x   = w_src[k].x + w_ys;
                n_work.y   = w_src[k].y - w_xs;
                n_work.acc = w_src[k].acc + atan_step(4'(k));
            end else begin
                n_work.x   = w_src[k].x - w_ys;
                n_work.y   = w_src[k].y + w_xs;
                n_work.acc = w_src[k].acc - atan_step(4'(k));
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (w_stage_ready[k]) begin
                r_valid[k] <= w_src_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_stage_ready[k] && w_src_valid[k]) begin
                r_work[k] <= n_work;
            end
        end
    end

endmodule

>>> hdl/cocda_map.sv
// Output stage: clamps the CORDIC angle, maps it by quadrant to a full-circle
// direction (0 with small_vector set for small vectors); output register. Depends on cocda_pkg.
module cocda_map
    import cocda_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_work    i_work,
    output logic     o_valid,
    input  logic     i_ready,
    output t_out_req o_req
);

    logic             r_valid;
    t_out_req         r_req;
    t_out_req         n_req;
    logic [ANG_W-1:0] w_angle;
    logic [DIR_W:0]   w_base;
    logic [DIR_W:0]   w_dir;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_req   = r_req;

    always_comb begin
        if (i_work.meta.x_zero) begin
            w_angle = QUARTER_TURN;
        end else if (i_work.acc < 0) begin
            w_angle = '0;
        end else if (i_work.acc > AW'(QUARTER_TURN)) begin
            w_angle = QUARTER_TURN;
        end else begin
            w_angle = i_work.acc[ANG_W-1:0];
        end
    end

    assign w_base = i_work.meta.x_neg ? DIR_3_QUARTER : DIR_QUARTER;

    // full turn wraps to 0 through truncation
    assign w_dir = (i_work.meta.x_neg ^ i_work.meta.y_neg)
                 ? (w_base - (DIR_W + 1)'(w_angle))
                 : (w_base + (DIR_W + 1)'(w_angle));

    always_comb begin
        if (i_work.meta.is_small) begin
            n_req.direction_angle = '0;
            n_req.small_vector    = 1'b1;
        end else begin
            n_req.direction_angle = w_dir[DIR_W-1:0];
            n_req.small_vector    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_req <= n_req;
        end
    end

endmodule

>>> hdl/cordic_octant_direction_angle_top.sv
// CORDIC octant direction angle, top level.
// Pipeline: input stage, one stage per CORDIC iteration, output stage.
// Throughput: one request per cycle while the output is not stalled.
// Every stage has its own valid bit and may fill while later stages stall.
// Synchronous active-low reset clears all valid bits; data registers are not reset.
// Depends on cocda_pkg, cocda_prep, cocda_cordic, cocda_map.
module cordic_octant_direction_angle_top
    import cocda_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_req  i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_out_req o_out_req
);

    logic  w_prep_valid;
    logic  w_prep_ready;
    t_work w_prep_work;
    logic  w_cordic_valid;
    logic  w_cordic_ready;
    t_work w_cordic_work;

    cocda_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_req   (i_in_req),
        .o_valid (w_prep_valid),
        .i_ready (w_prep_ready),
        .o_work  (w_prep_work)
    );

    cocda_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_prep_valid),
        .o_ready (w_prep_ready),
        .i_work  (w_prep_work),
        .o_valid (w_cordic_valid),
        .i_ready (w_cordic_ready),
        .o_work  (w_cordic_work)
    );

    cocda_map u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_cordic_valid),
        .o_ready (w_cordic_ready),
        .i_work  (w_cordic_work),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_req   (o_out_req)
    );

endmodule
